// ===== rtl/core/efr_pkg.sv =====
// Shared types and constants of the escaped command packet framer.
package efr_pkg;

	// Framing bytes.
	localparam logic [7:0] FRAME_START = 8'h7E;
	localparam logic [7:0] FRAME_STOP  = 8'h7F;
	localparam logic [7:0] FRAME_ESC   = 8'h7D;

	// Command code bytes.
	localparam logic [7:0] CODE_SPEED = 8'h01;
	localparam logic [7:0] CODE_PID   = 8'h02;

	// Packet shape.
	localparam int BYTES_PER_WORD = 4;
	localparam int INPUT_WORDS    = 3;

	// Byte queue between the front and the back.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// One classified line byte: the byte, whether it needs an escape, and end of packet.
	typedef struct packed {
		logic [7:0] data;
		logic       esc;
		logic       last;
	} token_t;

	// Queue status seen by the front and the back.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ===== rtl/core/efr_front.sv =====
// Front part: accepts a packet request and walks it into classified line bytes.
module efr_front
	import efr_pkg::*;
#(
	parameter int PAYLOAD_WORDS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [7:0]  device_id,
	input  logic [31:0] value_a,
	input  logic [31:0] value_b,
	input  logic [31:0] value_c,
	input  q_status_t   q_status,
	output logic        push,
	output token_t      push_token
);

	localparam int TOKENS = BYTES_PER_WORD * PAYLOAD_WORDS + 4;
	localparam int POS_W  = $clog2(TOKENS);
	localparam int WS_W   = POS_W - 2;
	localparam logic [POS_W-1:0] LAST_POS  = POS_W'(TOKENS - 1);
	localparam logic [POS_W-1:0] ID_POS    = POS_W'(1);
	localparam logic [POS_W-1:0] CODE_POS  = POS_W'(2);
	localparam logic [POS_W-1:0] FIRST_PAY = POS_W'(3);

	logic             busy_q;
	logic [POS_W-1:0] pos_q;
	logic             kind_q;
	logic [7:0]       id_q;
	logic [31:0]      word_q [INPUT_WORDS];

	logic             accept;
	logic [POS_W-1:0] pay_idx;
	logic [WS_W-1:0]  word_sel;
	logic [31:0]      word;
	logic [7:0]       pay_byte;

	assign in_stall = busy_q;
	assign accept   = in_valid && !busy_q;
	assign push     = busy_q && !q_status.full;

	// Request registers and the walk over packet positions.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
		end else if (push) begin
			if (pos_q == LAST_POS) begin
				busy_q <= 1'b0;
				pos_q  <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q    <= command;
			id_q      <= device_id;
			word_q[0] <= value_a;
			word_q[1] <= value_b;
			word_q[2] <= value_c;
		end
	end

	// Pick the payload byte; words past the held ones read as zero.
	always_comb begin
		pay_idx  = pos_q - FIRST_PAY;
		word_sel = pay_idx[POS_W-1:2];
		word     = '0;
		for (int i = 0; i < INPUT_WORDS; i++) begin
			if (i < PAYLOAD_WORDS && word_sel == WS_W'(i)) begin
				word = word_q[i];
			end
		end
		case (pay_idx[1:0])
			2'd0:    pay_byte = word[7:0];
			2'd1:    pay_byte = word[15:8];
			2'd2:    pay_byte = word[23:16];
			default: pay_byte = word[31:24];
		endcase
	end

	// Classify the byte at the current position.
	always_comb begin
		push_token.last = 1'b0;
		push_token.esc  = 1'b0;
		if (pos_q == '0) begin
			push_token.data = FRAME_START;
		end else if (pos_q == ID_POS) begin
			push_token.data = id_q;
		end else if (pos_q == CODE_POS) begin
			push_token.data = kind_q ? CODE_PID : CODE_SPEED;
		end else if (pos_q == LAST_POS) begin
			push_token.data = FRAME_STOP;
			push_token.last = 1'b1;
		end else begin
			push_token.data = pay_byte;
			push_token.esc  = (pay_byte == FRAME_START) || (pay_byte == FRAME_STOP) ||
				(pay_byte == FRAME_ESC);
		end
	end

endmodule

// ===== rtl/core/efr_queue.sv =====
// Short queue of classified line bytes between the front and the back.
module efr_queue
	import efr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  token_t    push_token,
	input  logic      pop,
	output token_t    head,
	output q_status_t q_status
);

	token_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign q_status.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign q_status.empty = (cnt_q == '0);
	assign head           = mem_q[rd_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_token;
		end
	end

endmodule

// ===== rtl/core/efr_back.sv =====
// Back part: sends queued bytes on the line, inserting the escape byte where marked.
module efr_back
	import efr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  token_t    head,
	input  q_status_t q_status,
	output logic      pop,
	output logic      esc_sent,
	output logic      out_valid,
	input  logic      out_stall,
	output logic [7:0] out_byte,
	output logic      last
);

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_q;
	logic       esc_sent_q;
	logic       slot_free;
	logic       send_esc;

	assign slot_free = !out_valid_q || !out_stall;
	assign send_esc  = head.esc && !esc_sent_q;
	assign pop       = slot_free && !q_status.empty && !send_esc;
	assign esc_sent  = esc_sent_q;
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

	// Output register control and escape tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			esc_sent_q  <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= !q_status.empty;
			if (!q_status.empty) begin
				esc_sent_q <= send_esc;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (slot_free && !q_status.empty) begin
			out_byte_q <= send_esc ? FRAME_ESC : head.data;
			last_q     <= send_esc ? 1'b0 : head.last;
		end
	end

endmodule

// ===== rtl/core/escaped_command_packet_framer_core.sv =====
// Top level of the escaped command packet framer: front, byte queue and back.
//
//  channel | direction | handshake             | payload
//  request | in        | in_valid / in_stall   | command, device_id, value_a..value_c
//  line    | out       | out_valid / out_stall | out_byte, last
//
// The line sends one byte per cycle unless stalled; a packet of 3 header bytes, 4 to 8
// per payload word and a stop byte is 4*PAYLOAD_WORDS+4 to 8*PAYLOAD_WORDS+4 bytes.
// The front takes one request and queues one classified byte per cycle while the queue
// has room; it takes the next request once all 4*PAYLOAD_WORDS+4 bytes of the current
// one are queued. Reset clears the control state at once; no clearing pass is needed.
// A stall on the line backs up the queue, and the front stalls requests while busy.
module escaped_command_packet_framer_core
	import efr_pkg::*;
#(
	parameter int PAYLOAD_WORDS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [7:0]  device_id,
	input  logic [31:0] value_a,
	input  logic [31:0] value_b,
	input  logic [31:0] value_c,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last
);

	q_status_t q_status;
	token_t    push_token;
	token_t    head;
	logic      push;
	logic      pop;
	logic      esc_sent;

	// Request intake and byte classification.
	efr_front #(
		.PAYLOAD_WORDS(PAYLOAD_WORDS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.device_id (device_id),
		.value_a   (value_a),
		.value_b   (value_b),
		.value_c   (value_c),
		.q_status  (q_status),
		.push      (push),
		.push_token(push_token)
	);

	// Byte queue.
	efr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_token(push_token),
		.pop       (pop),
		.head      (head),
		.q_status  (q_status)
	);

	// Line output with escape insertion.
	efr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.esc_sent (esc_sent),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte (out_byte),
		.last     (last)
	);

`ifndef SYNTHESIS
	// The end-of-packet byte is always the stop byte.
	a_last_is_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> out_byte == FRAME_STOP)
		else $error("last set on a byte other than the stop byte");

	// An escape in flight means its byte is still at the queue head.
	a_esc_has_byte: assert property (@(posedge clk) disable iff (!arst_n)
		esc_sent |-> !q_status.empty && head.esc)
		else $error("escape sent without its escaped byte queued");

	// While an escape is in flight, the line holds the escape byte, which never ends a packet.
	a_esc_follow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && esc_sent |-> out_byte == FRAME_ESC && !last)
		else $error("escape state does not match the byte on the line");
`endif

endmodule
